FILE: hdl/ucrr_pkg.sv
// Shared types, codes and descriptor tables for the control endpoint responder.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package ucrr_pkg;

  localparam logic [1:0] ACT_SETUP     = 2'd0;
  localparam logic [1:0] ACT_HOST_BYTE = 2'd1;
  localparam logic [1:0] ACT_IN_DONE   = 2'd2;
  localparam logic [1:0] ACT_BUS_RESET = 2'd3;

  localparam logic [2:0] SRC_NONE = 3'd0;
  localparam logic [2:0] SRC_DEV  = 3'd1;
  localparam logic [2:0] SRC_CFG  = 3'd2;
  localparam logic [2:0] SRC_LINE = 3'd3;
  localparam logic [2:0] SRC_WORD = 3'd4;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ZLP   = 2'd1;
  localparam logic [1:0] KIND_STALL = 2'd2;

  // {bRequest, bmRequestType}
  localparam logic [15:0] REQ_GET_DESC      = 16'h0680;
  localparam logic [15:0] REQ_SET_ADDR      = 16'h0500;
  localparam logic [15:0] REQ_SET_CONFIG    = 16'h0900;
  localparam logic [15:0] REQ_GET_CONFIG    = 16'h0880;
  localparam logic [15:0] REQ_STATUS_DEV    = 16'h0080;
  localparam logic [15:0] REQ_STATUS_IFC    = 16'h0081;
  localparam logic [15:0] REQ_STATUS_EP     = 16'h0082;
  localparam logic [15:0] REQ_CLR_FEAT_DEV  = 16'h0100;
  localparam logic [15:0] REQ_CLR_FEAT_IFC  = 16'h0101;
  localparam logic [15:0] REQ_CLR_FEAT_EP   = 16'h0102;
  localparam logic [15:0] REQ_SET_LINE      = 16'h2021;
  localparam logic [15:0] REQ_GET_LINE      = 16'h21A1;
  localparam logic [15:0] REQ_SET_CTRL_LINE = 16'h2221;

  localparam logic [15:0] DESC_DEVICE = 16'h0100;
  localparam logic [15:0] DESC_CONFIG = 16'h0200;

  localparam logic [6:0] DEV_DESC_LEN = 7'd18;
  localparam logic [6:0] CFG_DESC_LEN = 7'd67;
  localparam logic [6:0] LINE_LEN     = 7'd7;

  // Packet size range is 8..64, so 7 bits carry any beat count.
  localparam int EP0_PACKET_BYTES_DEF = 8;

  localparam logic [6:0][7:0] LINE_DEFAULT =
    {8'h08, 8'h00, 8'h00, 8'h00, 8'h01, 8'hC2, 8'h00};

  localparam logic [7:0] CFG_DESC [67] = '{
    8'h09, 8'h02, 8'h43, 8'h00, 8'h02, 8'h01, 8'h00, 8'hC0, 8'h00,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h02, 8'h02, 8'h00, 8'h00,
    8'h05, 8'h24, 8'h00, 8'h10, 8'h01,
    8'h04, 8'h24, 8'h02, 8'h00,
    8'h05, 8'h24, 8'h06, 8'h00, 8'h01,
    8'h05, 8'h24, 8'h01, 8'h00, 8'h01,
    8'h07, 8'h05, 8'h83, 8'h03, 8'h08, 8'h00, 8'hFF,
    8'h09, 8'h04, 8'h01, 8'h00, 8'h02, 8'h0A, 8'h00, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h82, 8'h02, 8'h40, 8'h00, 8'h00
  };

  function automatic logic [7:0] dev_byte(input logic [4:0] idx, input logic [7:0] pkt);
    logic [7:0] b;
    unique case (idx)
      5'd0:  b = 8'h12;
      5'd1:  b = 8'h01;
      5'd2:  b = 8'h10;
      5'd3:  b = 8'h01;
      5'd4:  b = 8'h02;
      5'd7:  b = pkt;
      5'd8:  b = 8'h25;
      5'd9:  b = 8'h05;
      5'd10: b = 8'hA7;
      5'd11: b = 8'hA4;
      5'd12: b = 8'h10;
      5'd13: b = 8'h01;
      5'd17: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    logic [7:0]  host_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] packet_kind;
    logic [7:0] data_byte;
    logic       last_of_packet;
  } result_t;

  // One packet to send: data run, ZLP or stall.
  typedef struct packed {
    logic [1:0]      kind;
    logic [2:0]      src;
    logic [6:0]      off;
    logic [6:0]      cnt;
    logic [15:0]     word;
    logic [6:0][7:0] lc;
  } pkt_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

FILE: hdl/ucrr_front.sv
// Request front end: decodes events, keeps device state, issues packet commands.
// Depends on ucrr_pkg.
`default_nettype none
module ucrr_front import ucrr_pkg::*; #(
  parameter int EP0_PACKET_BYTES = EP0_PACKET_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     take,
  input  wire item_t    item,
  output pkt_cmd_t      cmd,
  output logic          push
);

  localparam logic [6:0] PKT = 7'(EP0_PACKET_BYTES);

  logic [6:0]      device_address, device_address_next;
  logic            address_enabled, address_enabled_next;
  logic            configured_flag, configured_flag_next;
  logic [7:0]      configuration_value, configuration_value_next;
  logic [2:0]      endpoint_enables, endpoint_enables_next;
  logic [6:0][7:0] line_coding, line_coding_next;
  logic [2:0]      reply_source, reply_source_next;
  logic [6:0]      reply_offset, reply_offset_next;
  logic [6:0]      reply_remaining, reply_remaining_next;
  logic [15:0]     reply_word, reply_word_next;
  logic [15:0]     host_bytes_pending, host_bytes_pending_next;

  logic [15:0] req;
  logic [3:0]  ep;
  logic        start_en, do_send;
  logic [2:0]  start_src;
  logic [6:0]  start_len, n;
  logic        ep_ok, halted;

  function automatic logic [6:0] clip(input logic [6:0] full_len, input logic [15:0] lim);
    return (lim < {9'd0, full_len}) ? lim[6:0] : full_len;
  endfunction

  assign req = {item.request_code, item.request_type};
  assign ep  = item.request_index[3:0];
  assign ep_ok  = (configured_flag && ep <= 4'd3) || (address_enabled && ep == 4'd0);
  assign halted = (ep != 4'd0) && (ep <= 4'd3) && !endpoint_enables[2'(ep - 4'd1)];

  always_comb begin
    device_address_next      = device_address;
    address_enabled_next     = address_enabled;
    configured_flag_next     = configured_flag;
    configuration_value_next = configuration_value;
    endpoint_enables_next    = endpoint_enables;
    line_coding_next         = line_coding;
    reply_source_next        = reply_source;
    reply_offset_next        = reply_offset;
    reply_remaining_next     = reply_remaining;
    reply_word_next          = reply_word;
    host_bytes_pending_next  = host_bytes_pending;
    push      = 1'b0;
    cmd       = '0;
    cmd.lc    = line_coding;
    start_en  = 1'b0;
    start_src = SRC_NONE;
    start_len = '0;
    do_send   = 1'b0;
    n         = '0;
    if (take) begin
      unique case (item.action)
        ACT_SETUP: begin
          reply_source_next       = SRC_NONE;
          reply_offset_next       = '0;
          reply_remaining_next    = '0;
          host_bytes_pending_next = '0;
          unique case (req)
            REQ_GET_DESC: begin
              if (item.request_value == DESC_DEVICE) begin
                start_en  = 1'b1;
                start_src = SRC_DEV;
                start_len = clip(DEV_DESC_LEN, item.request_length);
              end else if (item.request_value == DESC_CONFIG) begin
                start_en  = 1'b1;
                start_src = SRC_CFG;
                start_len = clip(CFG_DESC_LEN, item.request_length);
              end else begin
                push = 1'b1;
                cmd.kind = KIND_STALL;
              end
            end
            REQ_SET_ADDR: begin
              device_address_next  = item.request_value[6:0];
              address_enabled_next = item.request_value != 16'd0;
              configured_flag_next = 1'b0;
              push = 1'b1;
              cmd.kind = KIND_ZLP;
            end
            REQ_SET_CONFIG: begin
              configuration_value_next = item.request_value[7:0];
              if (item.request_value != 16'd0) begin
                configured_flag_next  = 1'b1;
                endpoint_enables_next = 3'b111;
              end else begin
                configured_flag_next  = 1'b0;
                endpoint_enables_next = 3'b000;
                address_enabled_next  = 1'b1;
              end
              push = 1'b1;
              cmd.kind = KIND_ZLP;
            end
            REQ_GET_CONFIG: begin
              reply_word_next = {8'd0, configuration_value};
              start_en  = 1'b1;
              start_src = SRC_WORD;
              start_len = 7'd1;
            end
            REQ_STATUS_DEV, REQ_STATUS_IFC: begin
              reply_word_next = '0;
              start_en  = 1'b1;
              start_src = SRC_WORD;
              start_len = 7'd2;
            end
            REQ_STATUS_EP: begin
              if (ep_ok) begin
                reply_word_next = {15'd0, halted};
                start_en  = 1'b1;
                start_src = SRC_WORD;
                start_len = 7'd2;
              end else begin
                push = 1'b1;
                cmd.kind = KIND_STALL;
              end
            end
            REQ_CLR_FEAT_IFC, REQ_SET_CTRL_LINE: begin
              push = 1'b1;
              cmd.kind = KIND_ZLP;
            end
            REQ_CLR_FEAT_EP: begin
              push = 1'b1;
              if (item.request_value == 16'd0 && ep >= 4'd1 && ep <= 4'd3) begin
                endpoint_enables_next[2'(ep - 4'd1)] = 1'b1;
                cmd.kind = KIND_ZLP;
              end else begin
                cmd.kind = KIND_STALL;
              end
            end
            REQ_SET_LINE: begin
              if (item.request_length == 16'd0) begin
                push = 1'b1;
                cmd.kind = KIND_ZLP;
              end else begin
                host_bytes_pending_next = item.request_length;
              end
            end
            REQ_GET_LINE: begin
              start_en  = 1'b1;
              start_src = SRC_LINE;
              start_len = clip(LINE_LEN, item.request_length);
            end
            default: begin
              push = 1'b1;
              cmd.kind = KIND_STALL;
            end
          endcase
        end
        ACT_HOST_BYTE: begin
          if (host_bytes_pending != 16'd0) begin
            if (reply_offset < LINE_LEN) begin
              line_coding_next[reply_offset[2:0]] = item.host_byte;
              reply_offset_next = reply_offset + 7'd1;
            end
            host_bytes_pending_next = host_bytes_pending - 16'd1;
            if (host_bytes_pending == 16'd1) begin
              reply_offset_next = '0;
              push = 1'b1;
              cmd.kind = KIND_ZLP;
            end
          end
        end
        ACT_IN_DONE: begin
          if (reply_source != SRC_NONE) begin
            if (reply_remaining != 7'd0) begin
              do_send = 1'b1;
            end else begin
              reply_source_next = SRC_NONE;
              reply_offset_next = '0;
            end
          end
        end
        ACT_BUS_RESET: begin
          device_address_next      = '0;
          address_enabled_next     = 1'b0;
          configured_flag_next     = 1'b0;
          configuration_value_next = '0;
          endpoint_enables_next    = '0;
          reply_source_next        = SRC_NONE;
          reply_offset_next        = '0;
          reply_remaining_next     = '0;
          reply_word_next          = '0;
          host_bytes_pending_next  = '0;
        end
        default: ;
      endcase
      if (start_en) begin
        reply_source_next    = start_src;
        reply_offset_next    = '0;
        reply_remaining_next = start_len;
        do_send = 1'b1;
      end
      if (do_send) begin
        n = (reply_remaining_next > PKT) ? PKT : reply_remaining_next;
        push = 1'b1;
        if (n == 7'd0) begin
          cmd.kind = KIND_ZLP;
        end else begin
          cmd.kind = KIND_DATA;
          cmd.src  = reply_source_next;
          cmd.off  = reply_offset_next;
          cmd.cnt  = n;
          cmd.word = reply_word_next;
          reply_offset_next    = reply_offset_next + n;
          reply_remaining_next = reply_remaining_next - n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address      <= '0;
      address_enabled     <= 1'b0;
      configured_flag     <= 1'b0;
      configuration_value <= '0;
      endpoint_enables    <= '0;
      line_coding         <= LINE_DEFAULT;
      reply_source        <= SRC_NONE;
      reply_offset        <= '0;
      reply_remaining     <= '0;
      reply_word          <= '0;
      host_bytes_pending  <= '0;
    end else begin
      device_address      <= device_address_next;
      address_enabled     <= address_enabled_next;
      configured_flag     <= configured_flag_next;
      configuration_value <= configuration_value_next;
      endpoint_enables    <= endpoint_enables_next;
      line_coding         <= line_coding_next;
      reply_source        <= reply_source_next;
      reply_offset        <= reply_offset_next;
      reply_remaining     <= reply_remaining_next;
      reply_word          <= reply_word_next;
      host_bytes_pending  <= host_bytes_pending_next;
    end
  end

  // device_address is held for completeness of the device state; nothing reads it out.
  logic unused_addr;
  assign unused_addr = ^device_address;

endmodule
`default_nettype wire

FILE: hdl/ucrr_queue.sv
// Two-entry command queue between the front end and the packet sender.
// Depends on ucrr_pkg.
`default_nettype none
module ucrr_queue import ucrr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire pkt_cmd_t wdata,
  input  wire logic     pop,
  output pkt_cmd_t      head,
  output q_stat_t       stat
);

  pkt_cmd_t   ent [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign head       = ent[rptr];
  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      ent[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push && !stat.full) wptr <= !wptr;
      if (pop && !stat.empty) rptr <= !rptr;
      count <= count + 2'(push && !stat.full) - 2'(pop && !stat.empty);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ucrr_back.sv
// Packet sender: walks the head command one beat per cycle onto the result channel while result_ready is high.
// Depends on ucrr_pkg.
`default_nettype none
module ucrr_back import ucrr_pkg::*; #(
  parameter int EP0_PACKET_BYTES = EP0_PACKET_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire pkt_cmd_t head,
  input  wire q_stat_t  stat,
  output logic          pop,
  output logic          result_valid,
  input  wire logic     result_ready,
  output result_t       result
);

  logic [6:0] k;
  logic [7:0] idx;
  logic [7:0] b;
  logic       last;

  assign idx = {1'b0, head.off} + {1'b0, k};

  always_comb begin
    unique case (head.src)
      SRC_DEV:  b = (idx < {1'b0, DEV_DESC_LEN}) ?
                    dev_byte(idx[4:0], 8'(EP0_PACKET_BYTES)) : 8'h00;
      SRC_CFG:  b = (idx < {1'b0, CFG_DESC_LEN}) ? CFG_DESC[idx[6:0]] : 8'h00;
      SRC_LINE: b = (idx < {1'b0, LINE_LEN}) ? head.lc[idx[2:0]] : 8'h00;
      SRC_WORD: b = (idx == 8'd0) ? head.word[7:0] :
                    (idx == 8'd1) ? head.word[15:8] : 8'h00;
      default:  b = 8'h00;
    endcase
  end

  assign last         = (head.kind != KIND_DATA) || (k == head.cnt - 7'd1);
  assign result_valid = !stat.empty;
  assign pop          = result_valid && result_ready && last;

  always_comb begin
    result.packet_kind    = head.kind;
    result.data_byte      = (head.kind == KIND_DATA) ? b : 8'h00;
    result.last_of_packet = last;
  end

  // advance within a data run, restart on the next command
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (result_valid && result_ready) begin
      k <= last ? 7'd0 : k + 7'd1;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/usb_control_request_responder.sv
// Top level of the USB CDC control endpoint responder: front end, queue, sender.
// Depends on ucrr_pkg, ucrr_front, ucrr_queue, ucrr_back.
//
//   channel   direction  handshake                    beat
//   item      in         item_valid / item_ready      one event (setup, byte, done, reset)
//   result    out        result_valid / result_ready  one data byte, ZLP or stall
//
// An item is taken every cycle while the two-entry command queue has room.
// The sender puts out one beat per cycle while result_ready is high: one beat per data
// byte and a single beat for a ZLP or stall; the sender sets the sustained rate.
// Synchronous reset restores the default line coding and empties the queue.
// Either side may stall; the queue lets the front keep taking items meanwhile.
`default_nettype none
module usb_control_request_responder import ucrr_pkg::*; #(
  parameter int EP0_PACKET_BYTES = EP0_PACKET_BYTES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  pkt_cmd_t cmd, head;
  logic     push, pop;
  q_stat_t  stat;

  assign item_ready = !stat.full;

  ucrr_front #(.EP0_PACKET_BYTES(EP0_PACKET_BYTES)) u_front (
    .clk  (clk),
    .rst  (rst),
    .take (item_valid && item_ready),
    .item (item),
    .cmd  (cmd),
    .push (push)
  );

  ucrr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  ucrr_back #(.EP0_PACKET_BYTES(EP0_PACKET_BYTES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .stat         (stat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.packet_kind != KIND_DATA |-> result.last_of_packet)
    else $error("ZLP or stall beat without last flag");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.packet_kind != 2'd3)
    else $error("illegal packet kind");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("command pushed into a full queue");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire
